FILE: src/dqb_pkg.sv
// Shared types, constants and helper functions for the DNS query builder.
// Used by dqb_front, dqb_back, dns_query_builder and tb. No other dependencies.
`default_nettype none

package dqb_pkg;

	// Offset and header geometry
	localparam int OFF_W             = 16;
	localparam int MAX_LABEL_LENGTH  = 63;
	localparam int LBL_W             = 7;
	localparam logic [OFF_W-1:0] HDR_BYTES  = 16'd12;
	localparam logic [OFF_W-1:0] FIRST_CHAR = 16'd13;
	localparam logic [OFF_W-1:0] OFF_MAX    = 16'hFFFF;
	localparam logic [OFF_W-1:0] CAP_RESET  = 16'd512;
	localparam logic [3:0]       HDR_LAST_IDX = 4'd11;
	localparam logic [3:0]       TAIL_LAST_IDX = 4'd3;
	localparam logic [3:0]       TAIL_ONE_IDX = 4'd2;
	localparam logic [7:0]       DOT_CHAR   = 8'h2E;
	localparam logic [7:0]       HDR_FLAGS  = 8'h01;
	localparam logic [7:0]       HDR_QDCNT  = 8'h01;
	localparam logic [7:0]       QTYPE_LO   = 8'h01;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_AW        = 2;

	// Configuration register indexes
	typedef enum logic {
		REG_TID = 1'b0,
		REG_CAP = 1'b1
	} cfg_reg_t;

	// Completion status
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_LONG  = 2'd2
	} stat_t;

	// Request classes
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_DOT  = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		SEQ_ITEM = 2'd0,
		SEQ_HDR  = 2'd1,
		SEQ_TAIL = 2'd2,
		SEQ_FIN  = 2'd3
	} seq_t;

	// Input request payload
	typedef struct packed {
		logic       func;
		logic [7:0] name_char;
	} item_t;

	// Result payload
	typedef struct packed {
		logic             write_valid;
		logic [OFF_W-1:0] write_offset;
		logic [7:0]       write_byte;
		logic             done_res;
		stat_t            status;
		logic [OFF_W-1:0] message_length;
		logic             last_of_item;
	} result_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] ch;
	} qhead_t;

	// Saturating increment of an offset
	function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] x);
		sat_inc = (x == OFF_MAX) ? x : x + 16'd1;
	endfunction

	// Header byte at a given index
	function automatic logic [7:0] hdr_byte(input logic [3:0] idx,
		input logic [15:0] tid);
		unique case (idx)
			4'd0:    hdr_byte = tid[15:8];
			4'd1:    hdr_byte = tid[7:0];
			4'd2:    hdr_byte = HDR_FLAGS;
			4'd5:    hdr_byte = HDR_QDCNT;
			default: hdr_byte = 8'h00;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: src/dqb_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on dqb_pkg.
`default_nettype none

module dqb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  dqb_pkg::item_t     item,
	output dqb_pkg::qhead_t    head,
	input  wire logic          head_pop
);
	import dqb_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} qent_t;

	qent_t           mem_q [QUEUE_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            push;
	logic            pop;
	qent_t           ent;

	// Classify the request
	always_comb begin
		ent.ch = item.name_char;
		if (item.func)
			ent.kind = KIND_END;
		else if (item.name_char == DOT_CHAR)
			ent.kind = KIND_DOT;
		else
			ent.kind = KIND_CHAR;
	end

	assign item_stall = (count_q == (Q_AW+1)'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign pop        = head_pop && (count_q != '0);

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= ent;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Head of queue
	always_comb begin
		head.valid = (count_q != '0);
		head.kind  = mem_q[rd_ptr_q].kind;
		head.ch    = mem_q[rd_ptr_q].ch;
	end

endmodule

`default_nettype wire

FILE: src/dqb_back.sv
// Back end: sequences header, label and trailer writes, holds name state, output register.
// Depends on dqb_pkg; fed by dqb_front.
`default_nettype none

module dqb_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  dqb_pkg::qhead_t    head,
	output logic               head_pop,
	input  wire logic [15:0]   tid,
	input  wire logic [15:0]   cap,
	output logic               result_valid,
	input  wire logic          result_stall,
	output dqb_pkg::result_t   result
);
	import dqb_pkg::*;

	seq_t             st_q, st_d;
	logic             hs_q, hs_d;
	logic [OFF_W-1:0] wp_q, wp_d;
	logic [OFF_W-1:0] ls_q, ls_d;
	logic [LBL_W-1:0] lc_q, lc_d;
	stat_t            err_q, err_d;
	logic [OFF_W-1:0] t_q, t_d;
	logic [3:0]       cnt_q, cnt_d;
	logic             rv_q;
	result_t          res_q, res;
	logic             adv;
	logic             emit;
	logic [OFF_W-1:0] cnt_off;
	logic [OFF_W-1:0] len_raw;

	assign adv     = !rv_q || !result_stall;
	assign cnt_off = {12'd0, cnt_q};
	assign len_raw = sat_inc(t_q);

	// Sequencer: next state and result
	always_comb begin
		st_d     = st_q;
		hs_d     = hs_q;
		wp_d     = wp_q;
		ls_d     = ls_q;
		lc_d     = lc_q;
		err_d    = err_q;
		t_d      = t_q;
		cnt_d    = cnt_q;
		emit     = 1'b0;
		head_pop = 1'b0;
		res      = '0;
		res.status = STAT_OK;
		unique case (st_q)
			SEQ_ITEM: begin
				if (head.valid && adv) begin
					if (err_q != STAT_OK) begin
						// after an error only the end request reports
						head_pop = 1'b1;
						if (head.kind == KIND_END) begin
							emit             = 1'b1;
							res.done_res     = 1'b1;
							res.status       = err_q;
							res.last_of_item = 1'b1;
							hs_d  = 1'b0;
							wp_d  = '0;
							ls_d  = HDR_BYTES;
							lc_d  = '0;
							err_d = STAT_OK;
						end
					end else if (!hs_q) begin
						st_d  = SEQ_HDR;
						cnt_d = '0;
					end else begin
						unique case (head.kind)
							KIND_DOT: begin
								head_pop = 1'b1;
								if (lc_q == '0) begin
									err_d = STAT_EMPTY;
								end else begin
									// write back the label length
									emit             = (ls_q < cap);
									res.write_valid  = 1'b1;
									res.write_offset = ls_q;
									res.write_byte   = {1'b0, lc_q};
									res.last_of_item = 1'b1;
									ls_d = wp_q;
									wp_d = sat_inc(wp_q);
									lc_d = '0;
								end
							end
							KIND_CHAR: begin
								head_pop = 1'b1;
								if (lc_q >= LBL_W'(MAX_LABEL_LENGTH)) begin
									err_d = STAT_LONG;
								end else begin
									emit             = (wp_q < cap);
									res.write_valid  = 1'b1;
									res.write_offset = wp_q;
									res.write_byte   = head.ch;
									res.last_of_item = 1'b1;
									wp_d = sat_inc(wp_q);
									lc_d = lc_q + 1'b1;
								end
							end
							KIND_END: begin
								// close the open label, then the trailer
								if (lc_q != '0) begin
									emit             = (ls_q < cap);
									res.write_valid  = 1'b1;
									res.write_offset = ls_q;
									res.write_byte   = {1'b0, lc_q};
									t_d = wp_q;
								end else begin
									t_d = ls_q;
								end
								st_d  = SEQ_TAIL;
								cnt_d = '0;
							end
							default: head_pop = 1'b1;
						endcase
					end
				end
			end
			SEQ_HDR: begin
				if (adv) begin
					emit             = (cnt_off < cap);
					res.write_valid  = 1'b1;
					res.write_offset = cnt_off;
					res.write_byte   = hdr_byte(cnt_q, tid);
					// last only if the rest of the item writes nothing
					if (head.kind == KIND_END)
						res.last_of_item = 1'b0;
					else if (cnt_q == HDR_LAST_IDX)
						res.last_of_item = (head.kind == KIND_DOT) || !(FIRST_CHAR < cap);
					else
						res.last_of_item = ((cnt_off + 16'd1) >= cap);
					if (cnt_q == HDR_LAST_IDX) begin
						hs_d = 1'b1;
						ls_d = HDR_BYTES;
						wp_d = FIRST_CHAR;
						lc_d = '0;
						st_d = SEQ_ITEM;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			SEQ_TAIL: begin
				if (adv) begin
					// terminator, both type bytes and the class high byte
					emit             = (t_q < cap);
					res.write_valid  = 1'b1;
					res.write_offset = t_q;
					res.write_byte   = (cnt_q == TAIL_ONE_IDX) ? QTYPE_LO : 8'h00;
					t_d   = sat_inc(t_q);
					cnt_d = cnt_q + 1'b1;
					if (cnt_q == TAIL_LAST_IDX)
						st_d = SEQ_FIN;
				end
			end
			SEQ_FIN: begin
				if (adv) begin
					// last class byte carries completion
					emit     = 1'b1;
					head_pop = 1'b1;
					if (t_q < cap) begin
						res.write_valid  = 1'b1;
						res.write_offset = t_q;
						res.write_byte   = QTYPE_LO;
					end
					res.done_res       = 1'b1;
					res.message_length = (len_raw > cap) ? cap : len_raw;
					res.last_of_item   = 1'b1;
					hs_d  = 1'b0;
					wp_d  = '0;
					ls_d  = HDR_BYTES;
					lc_d  = '0;
					err_d = STAT_OK;
					st_d  = SEQ_ITEM;
				end
			end
			default: st_d = SEQ_ITEM;
		endcase
	end

	// Sequencer and name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= SEQ_ITEM;
			hs_q  <= 1'b0;
			wp_q  <= '0;
			ls_q  <= HDR_BYTES;
			lc_q  <= '0;
			err_q <= STAT_OK;
			t_q   <= '0;
			cnt_q <= '0;
		end else begin
			st_q  <= st_d;
			hs_q  <= hs_d;
			wp_q  <= wp_d;
			ls_q  <= ls_d;
			lc_q  <= lc_d;
			err_q <= err_d;
			t_q   <= t_d;
			cnt_q <= cnt_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rv_q <= 1'b0;
		else if (adv)
			rv_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			res_q <= res;
	end

	assign result_valid = rv_q;
	assign result       = res_q;

	// Checks
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && res_q.done_res |-> res_q.last_of_item)
		else $error("done result not marked last");

	a_no_hdr_no_label: assert property (@(posedge clk) disable iff (!arst_n)
		!hs_q |-> (lc_q == '0))
		else $error("label count without header");

	a_pop_state: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> (st_q == SEQ_ITEM || st_q == SEQ_FIN))
		else $error("queue popped mid-sequence");

	a_label_max: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= LBL_W'(MAX_LABEL_LENGTH))
		else $error("label count over limit");

endmodule

`default_nettype wire

FILE: src/dns_query_builder.sv
// Top level of the DNS query builder: config registers, front end queue, back end sequencer.
// Depends on dqb_pkg, dqb_front and dqb_back.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     dqb_pkg::item_t (func, name_char)
//   result    out        result_valid / result_stall dqb_pkg::result_t
//   config    in         cfg_wr_en                   cfg_index, cfg_wdata
//
// Once the header is out, the back end writes a character request straight out; the first
// request of a name first sends the header bytes, and the end request writes the trailer.
// A request passes through the 4-entry request queue and then the output register.
// Reset clears the queue, the name state and the output register; config returns to defaults.
// A result stall holds the output register and the back end; the queue keeps taking
// requests until it is full.
`default_nettype none

module dns_query_builder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  dqb_pkg::item_t    item,
	output logic              result_valid,
	input  wire logic         result_stall,
	output dqb_pkg::result_t  result,
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_wdata
);
	import dqb_pkg::*;

	logic [15:0] tid_q;
	logic [15:0] cap_q;
	qhead_t      head;
	logic        head_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_q <= '0;
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TID: tid_q <= cfg_wdata;
				REG_CAP: cap_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dqb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head       (head),
		.head_pop   (head_pop)
	);

	dqb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_pop     (head_pop),
		.tid          (tid_q),
		.cap          (cap_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for dns_query_builder: drives query names one character per request,
// predicts every byte write and completion in its own model, and checks each result in order.
// Depends on dqb_pkg and the dns_query_builder RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dqb_pkg::*;

	// Request codes and message geometry
	localparam logic       FN_CHAR   = 1'b0;
	localparam logic       FN_END    = 1'b1;
	localparam logic [7:0] DOT_CH    = 8'h2E;
	localparam int         LABEL_MAX = 63;
	localparam int         HDR_LEN   = 12;
	localparam int         SETTLE    = 40;
	localparam int         HOLD_LEN  = 300;
	localparam int         PHASES    = 7;
	localparam int         PHASE_REQ = 20;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// One row of the directed sequence: either a register update or a request repeated
	typedef struct packed {
		bit          set_regs;
		logic [15:0] tid;
		logic [15:0] cap;
		logic        func;
		logic [7:0]  ch;
		logic [7:0]  reps;
		bit          typed;
		stat_t       want_st;
		logic [15:0] want_len;
	} dir_row_t;

	localparam int DIR_ROWS = 29;

	// set_regs, tid, cap, func, ch, reps, typed, status, length
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{0, 16'h0000, 16'd0, FN_END, 8'h00, 8'd1, 1, STAT_OK, 16'd17},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h00, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'hFF, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, DOT_CH, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h80, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h7F, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, DOT_CH, 8'd1, 1, STAT_OK, 16'd23},
		'{1, 16'hFFFF, 16'hFFFF, FN_CHAR, 8'h00, 8'd0, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h78, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, DOT_CH, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, 8'hFF, 8'd1, 1, STAT_OK, 16'd19},
		'{0, 16'h0000, 16'd0, FN_CHAR, DOT_CH, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, 8'h00, 8'd1, 1, STAT_EMPTY, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h61, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, DOT_CH, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, DOT_CH, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h62, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, 8'h00, 8'd1, 1, STAT_EMPTY, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h71, 8'd63, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, 8'h00, 8'd1, 1, STAT_OK, 16'd81},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h72, 8'd64, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h73, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, 8'h00, 8'd1, 1, STAT_LONG, 16'd0},
		'{1, 16'h0000, 16'd13, FN_CHAR, 8'h00, 8'd0, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, 8'h00, 8'd1, 1, STAT_OK, 16'd13},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h7A, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, DOT_CH, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_CHAR, 8'h6B, 8'd1, 0, STAT_OK, 16'd0},
		'{0, 16'h0000, 16'd0, FN_END, 8'h00, 8'd1, 1, STAT_OK, 16'd13}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = REG_TID;
	logic [15:0] cfg_wdata = 16'h0000;

	dns_query_builder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	// Predicted byte writes and completions, oldest first
	result_t owed_writes [$];

	// Model copy of the registers and of the name being built
	logic [15:0] tid_reg = 16'h0000;
	logic [15:0] cap_reg = 16'd512;
	logic        nm_hdr_sent = 1'b0;
	logic [15:0] nm_pos = 16'd0;
	logic [15:0] nm_lbl_start = 16'd12;
	logic [6:0]  nm_lbl_len = 7'd0;
	stat_t       nm_err = STAT_OK;

	int fails = 0;
	int shown = 0;
	int n_items = 0;
	int n_results = 0;
	int n_names = 0;
	int n_err_names = 0;
	int n_cfg = 0;
	int snd_gap_pct = 0;
	int rcv_stall_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;

	// Clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Backstop against a hung block
	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic string show(input result_t r);
		return $sformatf("wv %0b off %0d byte %02h done %0b st %0d len %0d last %0b",
			r.write_valid, r.write_offset, r.write_byte, r.done_res, r.status,
			r.message_length, r.last_of_item);
	endfunction

	task automatic note_fail(input string msg);
		fails++;
		if (shown < 10) begin
			shown++;
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// Queue one byte write unless it falls at or past the capacity
	task automatic put_write(input logic [15:0] off, input logic [7:0] b);
		result_t r;
		r = '0;
		if (off < cap_reg) begin
			r.write_valid = 1'b1;
			r.write_offset = off;
			r.write_byte = b;
			owed_writes.push_back(r);
		end
	endtask

	task automatic put_header();
		int i;
		logic [7:0] b;
		for (i = 0; i < HDR_LEN; i++) begin
			b = 8'h00;
			if (i == 0)
				b = tid_reg[15:8];
			else if (i == 1)
				b = tid_reg[7:0];
			else if (i == 2 || i == 5)
				b = 8'h01;
			put_write(16'(i), b);
		end
		nm_hdr_sent = 1'b1;
		nm_lbl_start = 16'(HDR_LEN);
		nm_pos = 16'(HDR_LEN + 1);
		nm_lbl_len = 7'd0;
	endtask

	// Next offset, pinned at the top of the offset range
	function automatic logic [15:0] bump(input logic [15:0] x);
		return (x == 16'hFFFF) ? x : x + 16'd1;
	endfunction

	// Work out the writes one accepted request causes and advance the name state
	task automatic builder_step(input logic fn, input logic [7:0] ch);
		int owed_at_start;
		logic [15:0] t;
		logic [15:0] len;
		result_t r;
		owed_at_start = owed_writes.size();
		r = '0;
		if (fn == FN_CHAR) begin
			if (nm_err == STAT_OK) begin
				if (!nm_hdr_sent)
					put_header();
				if (ch == DOT_CH) begin
					if (nm_lbl_len == 0) begin
						nm_err = STAT_EMPTY;
					end else begin
						// back-fill the length byte, reserve the next one
						put_write(nm_lbl_start, {1'b0, nm_lbl_len});
						nm_lbl_start = nm_pos;
						nm_pos = bump(nm_lbl_start);
						nm_lbl_len = 7'd0;
					end
				end else if (nm_lbl_len >= LABEL_MAX) begin
					nm_err = STAT_LONG;
				end else begin
					put_write(nm_pos, ch);
					nm_pos = bump(nm_pos);
					nm_lbl_len++;
				end
			end
		end else begin
			n_names++;
			if (nm_err != STAT_OK) begin
				n_err_names++;
				r.done_res = 1'b1;
				r.status = nm_err;
				owed_writes.push_back(r);
			end else begin
				if (!nm_hdr_sent)
					put_header();
				if (nm_lbl_len > 0) begin
					put_write(nm_lbl_start, {1'b0, nm_lbl_len});
					t = nm_pos;
				end else begin
					t = nm_lbl_start;
				end
				// terminator, then type and class
				put_write(t, 8'h00);
				t = bump(t);
				put_write(t, 8'h00);
				t = bump(t);
				put_write(t, 8'h01);
				t = bump(t);
				put_write(t, 8'h00);
				t = bump(t);
				len = bump(t);
				if (len > cap_reg)
					len = cap_reg;
				r.done_res = 1'b1;
				r.status = STAT_OK;
				r.message_length = len;
				if (t < cap_reg) begin
					r.write_valid = 1'b1;
					r.write_offset = t;
					r.write_byte = 8'h01;
				end
				owed_writes.push_back(r);
			end
			nm_hdr_sent = 1'b0;
			nm_pos = 16'd0;
			nm_lbl_start = 16'(HDR_LEN);
			nm_lbl_len = 7'd0;
			nm_err = STAT_OK;
		end
		if (owed_writes.size() > owed_at_start) begin
			r = owed_writes.pop_back();
			r.last_of_item = 1'b1;
			owed_writes.push_back(r);
		end
	endtask

	// Offer one request at the falling edge and hold it until taken
	task automatic send_request(input logic fn, input logic [7:0] ch);
		while ($urandom_range(99) < snd_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{func: fn, name_char: ch};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n_items++;
		builder_step(fn, ch);
		@(negedge clk);
	endtask

	// Let the block drain completely before touching registers
	task automatic settle();
		item_valid <= 1'b0;
		while (owed_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [15:0] tid, input logic [15:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TID;
		cfg_wdata <= tid;
		@(negedge clk);
		cfg_index <= REG_CAP;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tid_reg = tid;
		cap_reg = cap;
		n_cfg++;
	endtask

	function automatic logic [7:0] non_dot_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c == DOT_CH)
			c = 8'h2F;
		return c;
	endfunction

	// One random name: mostly well formed, some with stray dots, some plain noise
	task automatic send_name();
		int shape;
		int nlab;
		int len;
		int l;
		int k;
		shape = $urandom_range(99);
		if (shape < 75) begin
			nlab = $urandom_range(1, 4);
			for (l = 0; l < nlab; l++) begin
				k = $urandom_range(99);
				if (k < 85)
					len = $urandom_range(1, 12);
				else if (k < 93)
					len = $urandom_range(13, 62);
				else if (k < 97)
					len = LABEL_MAX;
				else
					len = $urandom_range(LABEL_MAX + 1, LABEL_MAX + 6);
				for (k = 0; k < len; k++)
					send_request(FN_CHAR, non_dot_char());
				// trailing dot now and then on the last label
				if (l < nlab - 1 || $urandom_range(3) == 0)
					send_request(FN_CHAR, DOT_CH);
			end
			send_request(FN_END, 8'($urandom_range(255)));
		end else if (shape < 90) begin
			len = $urandom_range(1, 12);
			for (k = 0; k < len; k++)
				send_request(FN_CHAR, ($urandom_range(99) < 35) ? DOT_CH :
					8'($urandom_range(255)));
			send_request(FN_END, 8'($urandom_range(255)));
		end else begin
			// may leave the name open for the next one
			len = $urandom_range(1, 6);
			for (k = 0; k < len; k++)
				send_request(($urandom_range(9) == 0) ? FN_END : FN_CHAR,
					8'($urandom_range(255)));
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_LEN - 1;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		result_t owed;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (owed_writes.size() == 0) begin
				note_fail({"unexpected result: ", show(result)});
			end else begin
				owed = owed_writes.pop_front();
				if (result.write_valid !== owed.write_valid ||
					result.write_offset !== owed.write_offset ||
					result.write_byte !== owed.write_byte ||
					result.done_res !== owed.done_res ||
					result.status !== owed.status ||
					result.message_length !== owed.message_length ||
					result.last_of_item !== owed.last_of_item)
					note_fail({"result mismatch\n  want ", show(owed), "\n  got  ",
						show(result)});
			end
		end
	end

	// Stimulus
	initial begin
		int r;
		int k;
		int ph;
		int ph_start;
		int waited;
		bit first_name;
		dir_row_t row;
		idle_mode_t mode;
		logic [15:0] tid;
		logic [15:0] cap;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows, checked against typed values where given
		for (r = 0; r < DIR_ROWS; r++) begin
			row = dir_rows[r];
			if (row.set_regs) begin
				settle();
				program_regs(row.tid, row.cap);
			end else begin
				for (k = 0; k < row.reps; k++)
					send_request(row.func, row.ch);
				if (row.typed && (owed_writes.size() == 0 ||
					owed_writes[owed_writes.size() - 1].status !== row.want_st ||
					owed_writes[owed_writes.size() - 1].message_length !== row.want_len))
					note_fail($sformatf("row %0d: completion not status %0d length %0d",
						r, row.want_st, row.want_len));
			end
		end

		// Random phases over several register settings and idle patterns
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			tid = 16'($urandom_range(65535));
			case (ph)
				0: cap = 16'hFFFF;
				1: begin
					tid = 16'hFFFF;
					cap = 16'd13;
				end
				2: cap = 16'($urandom_range(13, 40));
				3: cap = 16'($urandom_range(41, 300));
				4: begin
					tid = 16'h0000;
					cap = 16'd512;
				end
				5: cap = 16'($urandom_range(13, 65535));
				default: cap = 16'($urandom_range(20, 120));
			endcase
			program_regs(tid, cap);
			mode = idle_mode_t'(ph % 4);
			snd_gap_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 27 : 0;
			rcv_stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 27 : 0;
			ph_start = n_items;
			first_name = 1'b1;
			while (n_items - ph_start < PHASE_REQ) begin
				send_name();
				if (first_name) begin
					first_name = 1'b0;
					// back-pressure: receiver holds off while requests keep coming
					if (ph == 0)
						holds_asked++;
					// sender pause until the block has delivered everything
					if (ph == 3) begin
						item_valid <= 1'b0;
						while (owed_writes.size() != 0)
							@(posedge clk);
						@(negedge clk);
					end
				end
			end
			send_request(FN_END, 8'($urandom_range(255)));
		end

		// Drain
		item_valid <= 1'b0;
		waited = 0;
		while (owed_writes.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (owed_writes.size() != 0)
			note_fail($sformatf("%0d results never arrived", owed_writes.size()));

		$display("Sent %0d requests forming %0d names (%0d with label errors), %0d results seen",
			n_items, n_names, n_err_names, n_results);
		$display("across %0d register settings, capacity 13 to 65535, with stall and pause runs",
			n_cfg);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
src/dqb_pkg.sv
src/dqb_front.sv
src/dqb_back.sv
src/dns_query_builder.sv
verif/tb.sv
